// ===== hw/rtl/mvsu_pkg.sv =====
package mvsu_pkg;

   localparam int GRID_NX = 64;
   localparam int GRID_NY = 64;

   // Padded grid: one ghost layer on every side.
   localparam int ROW_LEN = GRID_NY + 2;
   localparam int COL_LEN = GRID_NX + 2;
   localparam int PX_W = $clog2(COL_LEN);
   localparam int PY_W = $clog2(ROW_LEN);
   localparam int LINE_ADDR_W = PY_W + 1;
   localparam int LINE_DEPTH = 2 ** LINE_ADDR_W;
   localparam int CELL_W = 12;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ISOTHERMAL_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA_MINUS_ONE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOUND_SPEED_SQ = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_Y = 3'd4;

   localparam logic [31:0] GAMMA_MINUS_ONE_RESET = 32'd26214;
   localparam logic [31:0] SOUND_SPEED_SQ_RESET = 32'd65536;
   localparam logic [31:0] COEF_RESET = 32'd65536;

   localparam logic [30:0] QUOT_MAX = 31'h7FFF_FFFF;
   localparam int DIV_BITS_PER_STEP = 4;
   localparam int DIV_STEPS = 32 / DIV_BITS_PER_STEP;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int JOB_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [30:0] density;
      logic signed [31:0] energy;
      logic signed [31:0] potential;
      logic signed [31:0] field_x;
      logic signed [31:0] field_y;
      logic signed [31:0] field_z;
      logic signed [31:0] vel_x_in;
      logic signed [31:0] vel_y_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x_out;
      logic signed [31:0] vel_y_out;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic last_cell;
   } rsp_type;

   typedef struct packed {
      logic isothermal_mode;
      logic [31:0] gamma_minus_one;
      logic [31:0] sound_speed_sq;
      logic [31:0] coef_x;
      logic [31:0] coef_y;
   } cfg_type;

   // Stencil terms of one face, already reduced to differences and averages.
   typedef struct packed {
      logic signed [32:0] dq;
      logic signed [32:0] bav;
      logic signed [32:0] dd;
      logic signed [32:0] bza;
      logic signed [32:0] bzd;
      logic signed [32:0] dpot;
      logic [30:0] rho_avg;
      logic signed [31:0] vel;
   } face_type;

   typedef struct packed {
      face_type face_x;
      face_type face_y;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic last_cell;
   } job_type;

endpackage

// ===== hw/rtl/mvsu_front.sv =====
module mvsu_front (
   input  logic               clock,
   input  logic               reset,
   input  mvsu_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  mvsu_pkg::req_type  req_payload,
   output logic               push_valid,
   input  logic               push_ready,
   output mvsu_pkg::job_type  push_job
);
   import mvsu_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_RD1 = 2'd1;
   localparam logic [1:0] F_RD2 = 2'd2;
   localparam logic [1:0] F_RD3 = 2'd3;

   function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
      return {v[31], v[31], v};
   endfunction

   logic [1:0] state_ff, state_in;
   logic [PX_W-1:0] px_ff, px_in;
   logic [PY_W-1:0] py_ff, py_in;
   req_type item_ff;
   req_type hold0_ff, hold1_ff, hold2_ff, hold3_ff;
   req_type rd_a_ff, rd_b_ff;
   req_type line_mem [LINE_DEPTH];

   logic accept, rd_en, wr_en, produce;
   logic par_s, par_o;
   logic [PY_W-1:0] py_dn, py_up;
   logic [LINE_ADDR_W-1:0] addr_a, addr_b;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == F_IDLE);
   assign par_s = px_ff[0];
   assign par_o = ~px_ff[0];
   assign py_dn = py_ff - PY_W'(1);
   assign py_up = py_ff + PY_W'(1);

   assign produce = (px_ff >= PX_W'(2)) && (py_ff >= PY_W'(1)) && (py_ff <= PY_W'(GRID_NY));
   assign push_valid = (state_ff == F_RD3) && produce;
   assign wr_en = (state_ff == F_RD3) && (push_ready || !produce);

   // Stencil rows: the other parity holds the center row, this parity the west row,
   // already overwritten by the incoming row below the current column.
   always_comb begin
      addr_a = {par_o, py_dn};
      addr_b = {par_o, py_ff};
      rd_en = 1'b0;
      case (state_ff)
         F_IDLE: begin
            rd_en = accept;
         end
         F_RD1: begin
            addr_a = {par_o, py_up};
            addr_b = {par_s, py_dn};
            rd_en = 1'b1;
         end
         F_RD2: begin
            addr_a = {par_s, py_ff};
            addr_b = {par_s, py_up};
            rd_en = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= line_mem[addr_a];
         rd_b_ff <= line_mem[addr_b];
      end
      if (wr_en) begin
         line_mem[{par_s, py_ff}] <= item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      if (state_ff == F_RD1) begin
         hold0_ff <= rd_a_ff;
         hold1_ff <= rd_b_ff;
      end
      if (state_ff == F_RD2) begin
         hold2_ff <= rd_a_ff;
         hold3_ff <= rd_b_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      px_in = px_ff;
      py_in = py_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_RD1;
            end
         end
         F_RD1: begin
            state_in = F_RD2;
         end
         F_RD2: begin
            state_in = F_RD3;
         end
         F_RD3: begin
            if (wr_en) begin
               state_in = F_IDLE;
               if (py_ff == PY_W'(ROW_LEN - 1)) begin
                  py_in = '0;
                  px_in = (px_ff == PX_W'(COL_LEN - 1)) ? '0 : px_ff + PX_W'(1);
               end else begin
                  py_in = py_up;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         px_ff <= '0;
         py_ff <= '0;
      end else begin
         state_ff <= state_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   // hold0 = center row at y-1, hold1 = center, hold2 = center at y+1,
   // hold3 = new row at y-1, rd_a = west, rd_b = west at y+1.
   logic signed [33:0] bysum4, bxsum4, bysh, bxsh;
   logic signed [32:0] by_hc, by_hw, bx_hc, bx_hs, bz_sx, bz_sy;
   logic signed [32:0] dq_iso_x, dq_iso_y, dq_adi_x, dq_adi_y;
   logic [31:0] rho_sum_x, rho_sum_y;

   always_comb begin
      bysum4 = ext34(hold1_ff.field_y) + ext34(rd_a_ff.field_y)
             + ext34(rd_b_ff.field_y) + ext34(hold2_ff.field_y);
      bxsum4 = ext34(hold1_ff.field_x) + ext34(hold0_ff.field_x)
             + ext34(hold3_ff.field_x) + ext34(item_ff.field_x);
      bysh = bysum4 >>> 2;
      bxsh = bxsum4 >>> 2;
      by_hc = (ext33(hold1_ff.field_y) + ext33(hold2_ff.field_y)) >>> 1;
      by_hw = (ext33(rd_a_ff.field_y) + ext33(rd_b_ff.field_y)) >>> 1;
      bx_hc = (ext33(hold1_ff.field_x) + ext33(item_ff.field_x)) >>> 1;
      bx_hs = (ext33(hold0_ff.field_x) + ext33(hold3_ff.field_x)) >>> 1;
      bz_sx = (ext33(hold1_ff.field_z) + ext33(rd_a_ff.field_z)) >>> 1;
      bz_sy = (ext33(hold1_ff.field_z) + ext33(hold0_ff.field_z)) >>> 1;
      dq_iso_x = $signed({2'b00, hold1_ff.density}) - $signed({2'b00, rd_a_ff.density});
      dq_iso_y = $signed({2'b00, hold1_ff.density}) - $signed({2'b00, hold0_ff.density});
      dq_adi_x = ext33(hold1_ff.energy) - ext33(rd_a_ff.energy);
      dq_adi_y = ext33(hold1_ff.energy) - ext33(hold0_ff.energy);
      rho_sum_x = {1'b0, hold1_ff.density} + {1'b0, rd_a_ff.density};
      rho_sum_y = {1'b0, hold1_ff.density} + {1'b0, hold0_ff.density};

      push_job.face_x.dq = cfg.isothermal_mode ? dq_iso_x : dq_adi_x;
      push_job.face_x.bav = bysh[32:0];
      push_job.face_x.dd = by_hc - by_hw;
      push_job.face_x.bza = bz_sx;
      push_job.face_x.bzd = ext33(hold1_ff.field_z) - ext33(rd_a_ff.field_z);
      push_job.face_x.dpot = ext33(hold1_ff.potential) - ext33(rd_a_ff.potential);
      push_job.face_x.rho_avg = rho_sum_x[31:1];
      push_job.face_x.vel = hold1_ff.vel_x_in;

      push_job.face_y.dq = cfg.isothermal_mode ? dq_iso_y : dq_adi_y;
      push_job.face_y.bav = bxsh[32:0];
      push_job.face_y.dd = bx_hc - bx_hs;
      push_job.face_y.bza = bz_sy;
      push_job.face_y.bzd = ext33(hold1_ff.field_z) - ext33(hold0_ff.field_z);
      push_job.face_y.dpot = ext33(hold1_ff.potential) - ext33(hold0_ff.potential);
      push_job.face_y.rho_avg = rho_sum_y[31:1];
      push_job.face_y.vel = hold1_ff.vel_y_in;

      push_job.cell_x = CELL_W'(px_ff - PX_W'(2));
      push_job.cell_y = CELL_W'(py_dn);
      push_job.last_cell = (px_ff == PX_W'(COL_LEN - 1)) && (py_ff == PY_W'(GRID_NY));
   end

   a_write_ends_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> state_ff == F_IDLE)
      else $error("front did not return to idle after the line write");

endmodule

// ===== hw/rtl/mvsu_queue.sv =====
module mvsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mvsu_pkg::job_type  push_job,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mvsu_pkg::job_type  pop_job
);
   import mvsu_pkg::*;

   localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

   job_type entries [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic push_fire, pop_fire;

   assign push_ready = (count_ff < COUNT_W'(JOB_QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop_valid && pop_ready;
   assign pop_job = entries[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(JOB_QUEUE_DEPTH))
      else $error("job queue holds more entries than it has");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("job queue lost a transfer");

endmodule

// ===== hw/rtl/mvsu_back.sv =====
module mvsu_back (
   input  logic               clock,
   input  logic               reset,
   input  mvsu_pkg::cfg_type  cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  mvsu_pkg::job_type  pop_job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mvsu_pkg::rsp_type  rsp_payload
);
   import mvsu_pkg::*;

   localparam logic [3:0] B_IDLE = 4'd0;
   localparam logic [3:0] B_M0 = 4'd1;
   localparam logic [3:0] B_M1 = 4'd2;
   localparam logic [3:0] B_M2 = 4'd3;
   localparam logic [3:0] B_M3 = 4'd4;
   localparam logic [3:0] B_ABS = 4'd5;
   localparam logic [3:0] B_CHK = 4'd6;
   localparam logic [3:0] B_DIV = 4'd7;
   localparam logic [3:0] B_T1 = 4'd8;
   localparam logic [3:0] B_T2 = 4'd9;
   localparam logic [3:0] B_T3 = 4'd10;
   localparam logic [3:0] B_OUT = 4'd11;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? (~v + 33'd1) : v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   logic [3:0] state_ff, state_in;
   job_type job_ff;
   logic face_ff;
   logic [49:0] prod_ff;
   logic prod_neg_ff;
   logic signed [63:0] acc_ff;
   logic [63:0] mag_ff;
   logic neg_ff, zero_ff;
   logic [31:0] rem_ff, dvd_ff, quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [30:0] quot_ff;
   logic signed [31:0] vx_ff, vy_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   face_type fc;
   logic [31:0] coef_sel, k_sel;
   logic [32:0] mul_a, mul_b;
   logic mul_neg, mul_en;
   logic [65:0] mul_full;
   logic signed [63:0] prod_ext, term;
   logic face_done;
   logic signed [31:0] face_res;
   logic [31:0] r_next, d_next, q_next;
   logic out_load;

   assign fc = face_ff ? job_ff.face_y : job_ff.face_x;
   assign coef_sel = face_ff ? cfg.coef_y : cfg.coef_x;
   assign k_sel = cfg.isothermal_mode ? cfg.sound_speed_sq : cfg.gamma_minus_one;
   assign pop_ready = (state_ff == B_IDLE);
   assign out_load = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // One shared multiplier on magnitudes; the sign rides along and is applied on
   // the following add.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_neg = 1'b0;
      mul_en = 1'b1;
      case (state_ff)
         B_M0: begin
            mul_a = {1'b0, k_sel};
            mul_b = mag33(fc.dq);
            mul_neg = fc.dq[32];
         end
         B_M1: begin
            mul_a = mag33(fc.bav);
            mul_b = mag33(fc.dd);
            mul_neg = fc.bav[32] ^ fc.dd[32];
         end
         B_M2: begin
            mul_a = mag33(fc.bza);
            mul_b = mag33(fc.bzd);
            mul_neg = fc.bza[32] ^ fc.bzd[32];
         end
         B_T1: begin
            mul_a = {1'b0, coef_sel};
            mul_b = {2'b00, quot_ff};
            mul_neg = neg_ff;
         end
         B_T2: begin
            mul_a = {1'b0, coef_sel};
            mul_b = mag33(fc.dpot);
            mul_neg = fc.dpot[32];
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_full = {33'd0, mul_a} * {33'd0, mul_b};
   assign prod_ext = $signed({14'd0, prod_ff});
   assign term = prod_neg_ff ? -prod_ext : prod_ext;

   // Restoring division, a few quotient bits per cycle.
   always_comb begin
      logic [31:0] r, d, q, r2;
      r = rem_ff;
      d = dvd_ff;
      q = quo_ff;
      for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
         r2 = {r[30:0], d[31]};
         d = {d[30:0], 1'b0};
         if (r2 >= {1'b0, fc.rho_avg}) begin
            r = r2 - {1'b0, fc.rho_avg};
            q = {q[30:0], 1'b1};
         end else begin
            r = r2;
            q = {q[30:0], 1'b0};
         end
      end
      r_next = r;
      d_next = d;
      q_next = q;
   end

   always_comb begin
      state_in = state_ff;
      face_done = 1'b0;
      face_res = sat32(acc_ff - term);
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               state_in = B_M0;
            end
         end
         B_M0: state_in = B_M1;
         B_M1: state_in = B_M2;
         B_M2: state_in = B_M3;
         B_M3: state_in = B_ABS;
         B_ABS: state_in = B_CHK;
         B_CHK: begin
            if (zero_ff) begin
               state_in = B_T1;
            end else if (fc.rho_avg == '0) begin
               // A zero face density drives the velocity against the force.
               face_done = 1'b1;
               face_res = neg_ff ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else if (mag_ff >= {18'd0, fc.rho_avg, 15'd0}) begin
               state_in = B_T1;
            end else begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = B_T1;
            end
         end
         B_T1: state_in = B_T2;
         B_T2: state_in = B_T3;
         B_T3: face_done = 1'b1;
         B_OUT: begin
            if (out_load) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (face_done) begin
         state_in = face_ff ? B_OUT : B_M0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         job_ff <= pop_job;
      end
      if (mul_en) begin
         prod_ff <= mul_full[65:16];
         prod_neg_ff <= mul_neg;
      end
      case (state_ff)
         B_M1: acc_ff <= term;
         B_M2: acc_ff <= acc_ff + term;
         B_M3: acc_ff <= acc_ff + term;
         B_ABS: begin
            mag_ff <= acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
            neg_ff <= acc_ff[63];
            zero_ff <= (acc_ff == '0);
         end
         B_CHK: begin
            quot_ff <= zero_ff ? '0 : QUOT_MAX;
            rem_ff <= mag_ff[47:16];
            dvd_ff <= {mag_ff[15:0], 16'd0};
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         B_DIV: begin
            rem_ff <= r_next;
            dvd_ff <= d_next;
            quo_ff <= q_next;
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            quot_ff <= q_next[30:0];
         end
         B_T2: acc_ff <= {{32{fc.vel[31]}}, fc.vel} - term;
         default: begin
         end
      endcase
      if (face_done) begin
         if (face_ff) begin
            vy_ff <= face_res;
         end else begin
            vx_ff <= face_res;
         end
      end
      if (out_load) begin
         rsp_ff.vel_x_out <= vx_ff;
         rsp_ff.vel_y_out <= vy_ff;
         rsp_ff.cell_x <= job_ff.cell_x;
         rsp_ff.cell_y <= job_ff.cell_y;
         rsp_ff.last_cell <= job_ff.last_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         face_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop_valid && pop_ready) begin
            face_ff <= 1'b0;
         end else if (face_done) begin
            face_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |-> !q_next[31])
      else $error("quotient overflowed past the saturation check");

endmodule

// ===== hw/rtl/mhd_velocity_source_update_unit.sv =====
// Velocity source step for a 2-D staggered MHD grid. Cells enter in raster order
// (outer x, inner y) over the padded grid of (GRID_NX+2) x (GRID_NY+2), ghost layer
// included; each interior cell gives one result with both updated face velocities
// once its east neighbor has arrived, and ghost cells and the first two rows give
// none. The front takes one cell at a time, paced by the six stencil reads from the
// two-row line buffer through its two read ports. The back does all products on one
// shared multiplier and divides by face density at 4 quotient bits a cycle, skipping
// division when a numerator is zero or saturates. A two-entry queue lets the front
// run ahead over ghost cells. Configuration must be written only while no cell is in
// flight; the block itself does not enforce this.
module mhd_velocity_source_update_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  mvsu_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mvsu_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_write_enable,
   input  logic [mvsu_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                           csr_write_data
);
   import mvsu_pkg::*;

   cfg_type cfg_ff;
   logic push_valid, push_ready, pop_valid, pop_ready;
   job_type push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.isothermal_mode <= 1'b0;
         cfg_ff.gamma_minus_one <= GAMMA_MINUS_ONE_RESET;
         cfg_ff.sound_speed_sq <= SOUND_SPEED_SQ_RESET;
         cfg_ff.coef_x <= COEF_RESET;
         cfg_ff.coef_y <= COEF_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ISOTHERMAL_MODE: cfg_ff.isothermal_mode <= csr_write_data[0];
            CSR_GAMMA_MINUS_ONE: cfg_ff.gamma_minus_one <= csr_write_data;
            CSR_SOUND_SPEED_SQ: cfg_ff.sound_speed_sq <= csr_write_data;
            CSR_COEF_X: cfg_ff.coef_x <= csr_write_data;
            CSR_COEF_Y: cfg_ff.coef_y <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   mvsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   mvsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   mvsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_job     (pop_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/mvsu_checker.sv =====
`timescale 1ns / 100ps

module mvsu_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  mvsu_pkg::req_type                req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  mvsu_pkg::rsp_type                rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [mvsu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_write_data,
   output int                               fail_count,
   output int                               velocities_due,
   output int                               velocities_seen
);
   import mvsu_pkg::*;

   localparam longint QMAX = 64'h7FFF_FFFF;

   cfg_type cfg_model;
   logic [30:0]        rho_line [2][ROW_LEN];
   logic signed [31:0] eng_line [2][ROW_LEN];
   logic signed [31:0] pot_line [2][ROW_LEN];
   logic signed [31:0] bx_line  [2][ROW_LEN];
   logic signed [31:0] by_line  [2][ROW_LEN];
   logic signed [31:0] bz_line  [2][ROW_LEN];
   logic [63:0]        vel_line [2][ROW_LEN];
   int unsigned        pad_x, pad_y;
   rsp_type            updated_velocities [$];

   assign velocities_due = updated_velocities.size();

   function automatic longint qmul(longint a, longint b);
      longint unsigned ua, ub;
      longint r;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      r = longint'((ua * ub) >> 16);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint face_velocity(longint vel, logic [31:0] coef, longint num,
                                            longint dpot, longint rho_sum);
      longint unsigned rho_face, mag, q;
      longint quot, k;
      k = longint'({32'd0, coef});
      rho_face = longint'(rho_sum) >> 1;
      quot = 0;
      if (num != 0) begin
         mag = (num < 0) ? -num : num;
         // An empty face cannot be divided by: the velocity is driven to the rail.
         if (rho_face == 0) return (num > 0) ? -64'sd2147483648 : 64'sd2147483647;
         q = mag / rho_face;
         if (q >= 32768) q = QMAX;
         else q = q * 65536 + ((mag % rho_face) * 65536) / rho_face;
         if (q > QMAX) q = QMAX;
         quot = (num < 0) ? -longint'(q) : longint'(q);
      end
      return clamp32(vel - qmul(k, quot) - qmul(k, dpot));
   endfunction

   task automatic predict_cell(input req_type c);
      int unsigned s, o, py;
      longint rc, rw, rs, ec, ew, es, pc, pw, ps;
      longint byc, byn, byw, bywn, bxc, bxs, bxe, bxes, bzc, bzw, bzs;
      longint k, dqx, dqy, numx, numy, vx, vy;
      rsp_type r;
      s = pad_x & 1;
      o = s ^ 1;
      py = pad_y;
      if (pad_x >= 2 && py >= 1 && py <= GRID_NY) begin
         rc = rho_line[o][py]; rw = rho_line[s][py]; rs = rho_line[o][py-1];
         ec = eng_line[o][py]; ew = eng_line[s][py]; es = eng_line[o][py-1];
         pc = pot_line[o][py]; pw = pot_line[s][py]; ps = pot_line[o][py-1];
         byc = by_line[o][py]; byn = by_line[o][py+1];
         byw = by_line[s][py]; bywn = by_line[s][py+1];
         bxc = bx_line[o][py]; bxs = bx_line[o][py-1];
         bxe = c.field_x; bxes = bx_line[s][py-1];
         bzc = bz_line[o][py]; bzw = bz_line[s][py]; bzs = bz_line[o][py-1];
         k = cfg_model.isothermal_mode ? longint'({32'd0, cfg_model.sound_speed_sq})
                                       : longint'({32'd0, cfg_model.gamma_minus_one});
         dqx = cfg_model.isothermal_mode ? rc - rw : ec - ew;
         dqy = cfg_model.isothermal_mode ? rc - rs : ec - es;
         numx = qmul(k, dqx)
              + qmul((byc + byw + bywn + byn) >>> 2, ((byc + byn) >>> 1) - ((byw + bywn) >>> 1))
              + qmul((bzc + bzw) >>> 1, bzc - bzw);
         numy = qmul(k, dqy)
              + qmul((bxc + bxs + bxes + bxe) >>> 2, ((bxc + bxe) >>> 1) - ((bxs + bxes) >>> 1))
              + qmul((bzc + bzs) >>> 1, bzc - bzs);
         vx = face_velocity(longint'($signed(vel_line[o][py][31:0])), cfg_model.coef_x,
                            numx, pc - pw, rc + rw);
         vy = face_velocity(longint'($signed(vel_line[o][py][63:32])), cfg_model.coef_y,
                            numy, pc - ps, rc + rs);
         r.vel_x_out = vx[31:0];
         r.vel_y_out = vy[31:0];
         r.cell_x = CELL_W'(pad_x - 2);
         r.cell_y = CELL_W'(py - 1);
         r.last_cell = (pad_x == GRID_NX + 1 && py == GRID_NY);
         updated_velocities.push_back(r);
      end
      rho_line[s][py] = c.density;
      eng_line[s][py] = c.energy;
      pot_line[s][py] = c.potential;
      bx_line[s][py] = c.field_x;
      by_line[s][py] = c.field_y;
      bz_line[s][py] = c.field_z;
      vel_line[s][py] = {c.vel_y_in, c.vel_x_in};
      if (py + 1 >= ROW_LEN) begin
         pad_y = 0;
         pad_x = (pad_x + 1 >= COL_LEN) ? 0 : pad_x + 1;
      end else begin
         pad_y = py + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %0s: got %0h, expected %0h (result %0d)", what, got, want,
               velocities_seen);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_model.isothermal_mode <= 1'b0;
         cfg_model.gamma_minus_one <= GAMMA_MINUS_ONE_RESET;
         cfg_model.sound_speed_sq <= SOUND_SPEED_SQ_RESET;
         cfg_model.coef_x <= COEF_RESET;
         cfg_model.coef_y <= COEF_RESET;
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < ROW_LEN; j++) begin
               rho_line[i][j] = '0; eng_line[i][j] = '0; pot_line[i][j] = '0;
               bx_line[i][j] = '0; by_line[i][j] = '0; bz_line[i][j] = '0;
               vel_line[i][j] = '0;
            end
         end
         pad_x = 0;
         pad_y = 0;
         updated_velocities.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ISOTHERMAL_MODE: cfg_model.isothermal_mode <= csr_write_data[0];
               CSR_GAMMA_MINUS_ONE: cfg_model.gamma_minus_one <= csr_write_data;
               CSR_SOUND_SPEED_SQ:  cfg_model.sound_speed_sq <= csr_write_data;
               CSR_COEF_X:          cfg_model.coef_x <= csr_write_data;
               CSR_COEF_Y:          cfg_model.coef_y <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_cell(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (updated_velocities.size() == 0) begin
               report_mismatch("result with none due, cell",
                               {rsp_payload.cell_x, rsp_payload.cell_y}, 0);
            end else begin
               want = updated_velocities.pop_front();
               if (rsp_payload.vel_x_out !== want.vel_x_out)
                  report_mismatch("vel_x_out", rsp_payload.vel_x_out, want.vel_x_out);
               if (rsp_payload.vel_y_out !== want.vel_y_out)
                  report_mismatch("vel_y_out", rsp_payload.vel_y_out, want.vel_y_out);
               if (rsp_payload.cell_x !== want.cell_x)
                  report_mismatch("cell_x", rsp_payload.cell_x, want.cell_x);
               if (rsp_payload.cell_y !== want.cell_y)
                  report_mismatch("cell_y", rsp_payload.cell_y, want.cell_y);
               if (rsp_payload.last_cell !== want.last_cell)
                  report_mismatch("last_cell", rsp_payload.last_cell, want.last_cell);
            end
            velocities_seen++;
         end
      end
   end

   initial begin
      fail_count = 0;
      velocities_seen = 0;
   end

endmodule

// ===== tb/tb_mhd_velocity_source_update_unit.sv =====
`timescale 1ns / 100ps

module tb_mhd_velocity_source_update_unit;
   import mvsu_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 120;
   localparam int PHASES = 8;
   localparam int CELLS_PER_PHASE = 66;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_write_data;

   int fail_count, velocities_due, velocities_seen;
   int sender_idle_pct, receiver_stall_pct;
   int cells_sent, quiet_cycles;

   mhd_velocity_source_update_unit dut (.*);

   mvsu_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("tb_mhd_velocity_source_update_unit: done, errors");
         $finish;
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0, 1: return $urandom();
         2:    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         3:    return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
         4, 5: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
         default: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      endcase
   endfunction

   function automatic req_type random_cell();
      req_type c;
      case ($urandom_range(7))
         0:       c.density = '0;
         1:       c.density = 31'h7FFF_FFFF;
         2, 3:    c.density = 31'($urandom_range(1, 1 << 20));
         default: c.density = 31'($urandom());
      endcase
      c.energy = random_word();
      c.potential = random_word();
      c.field_x = random_word();
      c.field_y = random_word();
      c.field_z = random_word();
      c.vel_x_in = random_word();
      c.vel_y_in = random_word();
      return c;
   endfunction

   task automatic send_cell(input req_type c);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= c;
      do @(posedge clock); while (!req_ready);
      cells_sent++;
   endtask

   // Wait for every result, then let cells with no result (ghosts) leave the pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      while (velocities_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_config(input logic iso, input logic [31:0] gm1,
                                 input logic [31:0] cs2, input logic [31:0] cx,
                                 input logic [31:0] cy);
      logic [31:0] vals [5];
      logic [CSR_INDEX_W-1:0] idx [5];
      vals = '{{31'd0, iso}, gm1, cs2, cx, cy};
      idx = '{CSR_ISOTHERMAL_MODE, CSR_GAMMA_MINUS_ONE, CSR_SOUND_SPEED_SQ,
              CSR_COEF_X, CSR_COEF_Y};
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      req_type c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_ISOTHERMAL_MODE;
      csr_write_data = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      cells_sent = 0;
      quiet_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes under the reset settings; density cycles through empty, full and 0x10000.
      for (int i = 0; i < 24; i++) begin
         c.density = (i % 3 == 0) ? 31'h0 : ((i % 3 == 1) ? 31'h7FFF_FFFF : 31'h1_0000);
         c.energy = (i & 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         c.potential = (i & 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         c.field_x = (i & 4) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         c.field_y = (i & 1) ? 32'sh8000_0000 : 32'sh0;
         c.field_z = (i & 8) ? 32'sh7FFF_FFFF : 32'shFFFF_FFFF;
         c.vel_x_in = (i & 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         c.vel_y_in = (i & 4) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         send_cell(c);
      end
      drain();

      // Each phase sends one padded row's worth of cells under new settings.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_config(1'b0, GAMMA_MINUS_ONE_RESET, SOUND_SPEED_SQ_RESET,
                              COEF_RESET, COEF_RESET);
            1: program_config(1'b1, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000);
            2: program_config(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
            3: program_config(1'b1, $urandom(), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
            4: program_config(1'b0, 32'h0, $urandom(), 32'h1, 32'h1);
            5: program_config(1'b1, $urandom(), 32'h0, $urandom(), $urandom());
            6: program_config(1'b0, $urandom(), $urandom(), $urandom(), $urandom());
            default: program_config(1'b1, $urandom_range(1 << 20), $urandom_range(1 << 18),
                                    $urandom_range(1 << 17), $urandom_range(1 << 17));
         endcase
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         for (int i = 0; i < CELLS_PER_PHASE; i++) send_cell(random_cell());
         drain();
      end

      $display("run covered %0d cells over %0d settings, %0d velocity results checked",
               cells_sent, PHASES + 1, velocities_seen);
      $display("with idle senders, stalling receivers, empty faces and extreme fields");
      if (fail_count == 0) begin
         $display("tb_mhd_velocity_source_update_unit: done, clean");
      end else begin
         $display("tb_mhd_velocity_source_update_unit: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mvsu_pkg.sv
hw/rtl/mvsu_front.sv
hw/rtl/mvsu_queue.sv
hw/rtl/mvsu_back.sv
hw/rtl/mhd_velocity_source_update_unit.sv
tb/mvsu_checker.sv
tb/tb_mhd_velocity_source_update_unit.sv
